### rtl/llu_pkg.sv
`default_nettype none

package llu_pkg;

    // Default number of CORDIC rotation cells, and the length of the arctangent table.
    localparam int unsigned CORDIC_STAGES_DEF = 30;
    localparam int unsigned TAB_LEN           = 32;
    localparam int unsigned TAB_IDX_W         = $clog2(TAB_LEN);

    // Field and datapath widths.
    localparam int unsigned ANG_W  = 32;   // Q3.28 input angles
    localparam int unsigned WRAP_W = 34;   // headroom for the longitude wrap
    localparam int unsigned DP_W   = 36;   // CORDIC x, y and z with 32 fraction bits
    localparam int unsigned OUT_W  = 32;   // Q1.30 results
    localparam int unsigned PROD_W = 2 * OUT_W;

    // Angle constants in Q3.28.
    localparam logic signed [WRAP_W-1:0] PI_Q28       = 34'sd843314857;
    localparam logic signed [WRAP_W-1:0] HALF_PI_Q28  = 34'sd421657428;
    localparam logic signed [WRAP_W-1:0] TWO_PI_Q28   = 34'sd1686629714;
    localparam logic signed [WRAP_W-1:0] THREE_PI_Q28 = 34'sd2529944571;
    localparam logic signed [WRAP_W-1:0] FOUR_PI_Q28  = 34'sd3373259428;

    // CORDIC constants with 32 fraction bits.
    localparam logic signed [DP_W-1:0] HALF_PI_Q32 = 36'sd6746518848;
    localparam logic signed [DP_W-1:0] GAIN_Q32    = 36'sd2608131496;

    // Unit value in Q1.30.
    localparam logic signed [OUT_W-1:0] ONE_Q30 = 32'sd1073741824;

    // One CORDIC rotator: cosine path, sine path and residual angle.
    typedef struct packed {
        logic signed [DP_W-1:0] x;
        logic signed [DP_W-1:0] y;
        logic signed [DP_W-1:0] z;
    } llu_rot_t;

    // Item state handed from cell to cell.
    typedef struct packed {
        llu_rot_t lat;
        llu_rot_t lon;
        logic     flip;
    } llu_cell_t;

endpackage

`default_nettype wire

### rtl/latlon_to_unit_vector_unit.sv
// Channel   Dir  Width  Contents
// s_*       in   64     lat_angle [31:0], lon_angle [63:32], both signed Q3.28 radians
// m_*       out  96     unit_x [31:0], unit_y [63:32], unit_z [95:64], signed Q1.30
//
// One item enters per clock unless a stall on m_tready has filled the chain: a
// clamp-and-wrap register and a fold register, one rotation cell per CORDIC stage, then scale,
// multiply and round. Reset clears only the valid flags of every stage.
// A stall on m_tready fills the chain one stage at a time; s_tready stays high
// as long as any stage downstream holds a bubble.
`default_nettype none

module latlon_to_unit_vector_unit #(
    parameter int unsigned CORDIC_STAGES = llu_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // lat_angle [31:0], lon_angle [63:32]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata    // unit_x [31:0], unit_y [63:32], unit_z [95:64]
);

    logic               [CORDIC_STAGES:0] chain_valid;
    logic               [CORDIC_STAGES:0] chain_ready;
    llu_pkg::llu_cell_t                   chain_data [CORDIC_STAGES+1];
    logic signed [llu_pkg::OUT_W-1:0]     unit_x;
    logic signed [llu_pkg::OUT_W-1:0]     unit_y;
    logic signed [llu_pkg::OUT_W-1:0]     unit_z;

    // Angle conditioning and CORDIC start vectors.
    llu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .lat_angle (s_tdata[31:0]),
        .lon_angle (s_tdata[63:32]),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    // Row of rotation cells, one per CORDIC stage.
    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cell
        llu_cell #(
            .STAGE_IDX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    // Scaling, products and output register.
    llu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[CORDIC_STAGES]),
        .in_ready  (chain_ready[CORDIC_STAGES]),
        .in_data   (chain_data[CORDIC_STAGES]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .unit_x    (unit_x),
        .unit_y    (unit_y),
        .unit_z    (unit_z)
    );

    assign m_tdata = {unit_z, unit_y, unit_x};

endmodule

`default_nettype wire

### rtl/llu_front.sv
`default_nettype none

module llu_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [llu_pkg::ANG_W-1:0] lat_angle,
    input  wire logic signed [llu_pkg::ANG_W-1:0] lon_angle,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output llu_pkg::llu_cell_t                  out_data
);

    logic                                s1_valid_reg;
    logic                                s1_ready;
    logic signed [llu_pkg::WRAP_W-1:0]   lat_clamp_next;
    logic signed [llu_pkg::WRAP_W-1:0]   lat_clamp_reg;
    logic signed [llu_pkg::WRAP_W-1:0]   lon_ext;
    logic signed [llu_pkg::WRAP_W-1:0]   lat_ext;
    logic signed [llu_pkg::WRAP_W-1:0]   lon_wrap_next;
    logic signed [llu_pkg::WRAP_W-1:0]   lon_wrap_reg;
    logic                                out_valid_reg;
    logic                                s2_ready;
    logic signed [llu_pkg::WRAP_W-1:0]   lon_fold;
    logic                                flip_next;
    llu_pkg::llu_cell_t                  cell_next;
    llu_pkg::llu_cell_t                  cell_reg;

    // Stage handshakes: a stage loads when it is empty or its successor takes its item.
    assign s2_ready  = !out_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = cell_reg;

    // Clamp latitude to the poles and wrap longitude into [-pi, pi).
    always_comb
    begin
        lat_ext = {{(llu_pkg::WRAP_W - llu_pkg::ANG_W){lat_angle[llu_pkg::ANG_W-1]}}, lat_angle};
        lon_ext = {{(llu_pkg::WRAP_W - llu_pkg::ANG_W){lon_angle[llu_pkg::ANG_W-1]}}, lon_angle};

        if (lat_ext > llu_pkg::HALF_PI_Q28)
            lat_clamp_next = llu_pkg::HALF_PI_Q28;
        else if (lat_ext < -llu_pkg::HALF_PI_Q28)
            lat_clamp_next = -llu_pkg::HALF_PI_Q28;
        else
            lat_clamp_next = lat_ext;

        if (lon_ext < -llu_pkg::THREE_PI_Q28)
            lon_wrap_next = lon_ext + llu_pkg::FOUR_PI_Q28;
        else if (lon_ext < -llu_pkg::PI_Q28)
            lon_wrap_next = lon_ext + llu_pkg::TWO_PI_Q28;
        else if (lon_ext < llu_pkg::PI_Q28)
            lon_wrap_next = lon_ext;
        else
            lon_wrap_next = lon_ext - llu_pkg::TWO_PI_Q28;
    end

    // Fold longitude into [-pi/2, pi/2] and load the CORDIC start vectors.
    always_comb
    begin
        flip_next = 1'b0;
        if (lon_wrap_reg > llu_pkg::HALF_PI_Q28)
        begin
            lon_fold  = lon_wrap_reg - llu_pkg::PI_Q28;
            flip_next = 1'b1;
        end
        else if (lon_wrap_reg < -llu_pkg::HALF_PI_Q28)
        begin
            lon_fold  = lon_wrap_reg + llu_pkg::PI_Q28;
            flip_next = 1'b1;
        end
        else
        begin
            lon_fold = lon_wrap_reg;
        end

        cell_next.lat.x = llu_pkg::GAIN_Q32;
        cell_next.lat.y = '0;
        cell_next.lat.z = {lat_clamp_reg[llu_pkg::ANG_W-1:0], 4'b0000};
        cell_next.lon.x = llu_pkg::GAIN_Q32;
        cell_next.lon.y = '0;
        cell_next.lon.z = {lon_fold[llu_pkg::ANG_W-1:0], 4'b0000};
        cell_next.flip  = flip_next;
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            lat_clamp_reg <= lat_clamp_next;
            lon_wrap_reg  <= lon_wrap_next;
        end
        if (s2_ready && s1_valid_reg)
            cell_reg <= cell_next;
    end

`ifndef SYNTHESIS
    // Both start angles lie within plus or minus pi/2 once clamped, wrapped and folded.
    a_start_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (cell_reg.lon.z <= llu_pkg::HALF_PI_Q32 &&
                           cell_reg.lon.z >= -llu_pkg::HALF_PI_Q32 &&
                           cell_reg.lat.z <= llu_pkg::HALF_PI_Q32 &&
                           cell_reg.lat.z >= -llu_pkg::HALF_PI_Q32))
        else $error("start angle outside plus or minus pi/2");
`endif

endmodule

`default_nettype wire

### rtl/llu_cell.sv
`default_nettype none

module llu_cell #(
    parameter int unsigned STAGE_IDX = 0
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire llu_pkg::llu_cell_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output llu_pkg::llu_cell_t      out_data
);

    localparam logic [llu_pkg::TAB_IDX_W-1:0] SHIFT = llu_pkg::TAB_IDX_W'(STAGE_IDX);

    logic                                 out_valid_reg;
    logic signed [llu_pkg::DP_W-1:0]      step_angle;
    llu_pkg::llu_cell_t                   cell_next;
    llu_pkg::llu_cell_t                   cell_reg;

    // Arctangent of 2^-i with 32 fraction bits, rounded.
    function automatic logic [31:0] atan_q32(input logic [llu_pkg::TAB_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd3373259426;
            5'd1:    v = 32'd1991351318;
            5'd2:    v = 32'd1052175346;
            5'd3:    v = 32'd534100635;
            5'd4:    v = 32'd268086748;
            5'd5:    v = 32'd134174063;
            5'd6:    v = 32'd67103403;
            5'd7:    v = 32'd33553749;
            5'd8:    v = 32'd16777131;
            5'd9:    v = 32'd8388597;
            5'd10:   v = 32'd4194303;
            default: v = 32'd1 << (6'd32 - {1'b0, idx});
        endcase
        return v;
    endfunction

    // One rotation toward zero residual angle.
    function automatic llu_pkg::llu_rot_t rotate(input llu_pkg::llu_rot_t a,
                                                 input logic signed [llu_pkg::DP_W-1:0] ang);
        llu_pkg::llu_rot_t               r;
        logic signed [llu_pkg::DP_W-1:0] dx;
        logic signed [llu_pkg::DP_W-1:0] dy;
        dx = a.y >>> SHIFT;
        dy = a.x >>> SHIFT;
        if (!a.z[llu_pkg::DP_W-1])
        begin
            r.x = a.x - dx;
            r.y = a.y + dy;
            r.z = a.z - ang;
        end
        else
        begin
            r.x = a.x + dx;
            r.y = a.y - dy;
            r.z = a.z + ang;
        end
        return r;
    endfunction

    assign step_angle = {{(llu_pkg::DP_W - 32){1'b0}}, atan_q32(SHIFT)};
    assign in_ready   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_data   = cell_reg;

    // Latitude and longitude rotators work side by side.
    always_comb
    begin
        cell_next.lat  = rotate(in_data.lat, step_angle);
        cell_next.lon  = rotate(in_data.lon, step_angle);
        cell_next.flip = in_data.flip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            cell_reg <= cell_next;
    end

endmodule

`default_nettype wire

### rtl/llu_back.sv
`default_nettype none

module llu_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire llu_pkg::llu_cell_t           in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [llu_pkg::OUT_W-1:0]  unit_x,
    output logic signed [llu_pkg::OUT_W-1:0]  unit_y,
    output logic signed [llu_pkg::OUT_W-1:0]  unit_z
);

    logic                                  b1_valid_reg;
    logic                                  b2_valid_reg;
    logic                                  out_valid_reg;
    logic                                  b1_ready;
    logic                                  b2_ready;
    logic                                  b3_ready;
    logic signed [llu_pkg::OUT_W-1:0]      clat_next;
    logic signed [llu_pkg::OUT_W-1:0]      slat_next;
    logic signed [llu_pkg::OUT_W-1:0]      clon_next;
    logic signed [llu_pkg::OUT_W-1:0]      slon_next;
    logic signed [llu_pkg::OUT_W-1:0]      clat_reg;
    logic signed [llu_pkg::OUT_W-1:0]      slat_reg;
    logic signed [llu_pkg::OUT_W-1:0]      clon_reg;
    logic signed [llu_pkg::OUT_W-1:0]      slon_reg;
    logic signed [llu_pkg::PROD_W-1:0]     prod_x_reg;
    logic signed [llu_pkg::PROD_W-1:0]     prod_y_reg;
    logic signed [llu_pkg::OUT_W-1:0]      slat_b2_reg;
    logic signed [llu_pkg::OUT_W-1:0]      unit_x_reg;
    logic signed [llu_pkg::OUT_W-1:0]      unit_y_reg;
    logic signed [llu_pkg::OUT_W-1:0]      unit_z_reg;

    // Drop two fraction bits with rounding and saturate to plus or minus one.
    function automatic logic signed [llu_pkg::OUT_W-1:0] to_q30(
        input logic signed [llu_pkg::DP_W-1:0] v);
        logic signed [llu_pkg::DP_W-1:0] t;
        t = (v + llu_pkg::DP_W'(2)) >>> 2;
        if (t > llu_pkg::DP_W'(llu_pkg::ONE_Q30))
            return llu_pkg::ONE_Q30;
        else if (t < -llu_pkg::DP_W'(llu_pkg::ONE_Q30))
            return -llu_pkg::ONE_Q30;
        else
            return t[llu_pkg::OUT_W-1:0];
    endfunction

    // Bring a Q2.60 product back to Q1.30 with rounding and saturation.
    function automatic logic signed [llu_pkg::OUT_W-1:0] prod_to_q30(
        input logic signed [llu_pkg::PROD_W-1:0] p);
        logic signed [llu_pkg::PROD_W-1:0] t;
        t = (p + (llu_pkg::PROD_W'(1) << 29)) >>> 30;
        if (t > llu_pkg::PROD_W'(llu_pkg::ONE_Q30))
            return llu_pkg::ONE_Q30;
        else if (t < -llu_pkg::PROD_W'(llu_pkg::ONE_Q30))
            return -llu_pkg::ONE_Q30;
        else
            return t[llu_pkg::OUT_W-1:0];
    endfunction

    // Stage handshakes.
    assign b3_ready  = !out_valid_reg || out_ready;
    assign b2_ready  = !b2_valid_reg || b3_ready;
    assign b1_ready  = !b1_valid_reg || b2_ready;
    assign in_ready  = b1_ready;
    assign out_valid = out_valid_reg;
    assign unit_x    = unit_x_reg;
    assign unit_y    = unit_y_reg;
    assign unit_z    = unit_z_reg;

    // Scale the rotator outputs; a folded longitude negates its cosine and sine.
    always_comb
    begin
        clat_next = to_q30(in_data.lat.x);
        slat_next = to_q30(in_data.lat.y);
        clon_next = to_q30(in_data.lon.x);
        slon_next = to_q30(in_data.lon.y);
        if (in_data.flip)
        begin
            clon_next = -clon_next;
            slon_next = -slon_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (b1_ready)
                b1_valid_reg <= in_valid;
            if (b2_ready)
                b2_valid_reg <= b1_valid_reg;
            if (b3_ready)
                out_valid_reg <= b2_valid_reg;
        end
    end

    // Scale, multiply, then round into the output register.
    always_ff @(posedge clk)
    begin
        if (b1_ready && in_valid)
        begin
            clat_reg <= clat_next;
            slat_reg <= slat_next;
            clon_reg <= clon_next;
            slon_reg <= slon_next;
        end
        if (b2_ready && b1_valid_reg)
        begin
            prod_x_reg  <= clat_reg * clon_reg;
            prod_y_reg  <= clat_reg * slon_reg;
            slat_b2_reg <= slat_reg;
        end
        if (b3_ready && b2_valid_reg)
        begin
            unit_x_reg <= prod_to_q30(prod_x_reg);
            unit_y_reg <= prod_to_q30(prod_y_reg);
            unit_z_reg <= slat_b2_reg;
        end
    end

`ifndef SYNTHESIS
    // A scaled item waiting on the multiply stage keeps its operands.
    a_scale_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (b1_valid_reg && !b2_ready) |=>
            (b1_valid_reg && $stable(clat_reg) && $stable(clon_reg) && $stable(slon_reg)))
        else $error("scaled operands changed while stalled");

    // The products feeding the output come from a full item.
    a_prod_follows_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (b2_ready && b1_valid_reg) |=> b2_valid_reg)
        else $error("multiply stage lost an item");

    // Every delivered component stays within plus or minus one.
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (unit_x_reg <= llu_pkg::ONE_Q30 && unit_x_reg >= -llu_pkg::ONE_Q30 &&
                           unit_y_reg <= llu_pkg::ONE_Q30 && unit_y_reg >= -llu_pkg::ONE_Q30 &&
                           unit_z_reg <= llu_pkg::ONE_Q30 && unit_z_reg >= -llu_pkg::ONE_Q30))
        else $error("result component outside plus or minus one");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned STAGES  = llu_pkg::CORDIC_STAGES_DEF;
    localparam int unsigned LATENCY = STAGES + 5;
    localparam int unsigned RANDOM_ITEMS = 1450;

    // Angle constants widened to 64 bits for the predictor.
    localparam longint PI_L      = llu_pkg::PI_Q28;
    localparam longint HALF_PI_L = llu_pkg::HALF_PI_Q28;
    localparam longint TWO_PI_L  = llu_pkg::TWO_PI_Q28;
    localparam longint GAIN_L    = llu_pkg::GAIN_Q32;
    localparam longint ONE_L     = llu_pkg::ONE_Q30;

    // The same constants as 32-bit stimulus values.
    localparam int PI_I      = int'(llu_pkg::PI_Q28);
    localparam int HALF_PI_I = int'(llu_pkg::HALF_PI_Q28);

    typedef struct {
        logic signed [31:0] unit_x;
        logic signed [31:0] unit_y;
        logic signed [31:0] unit_z;
    } unit_vec_t;

    // One coordinate waiting to be sent, with its idle gap and an optional drain request.
    typedef struct {
        logic [31:0] lat;
        logic [31:0] lon;
        int unsigned gap;
        bit          drain;
    } coord_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // lat_angle [31:0], lon_angle [63:32]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;        // unit_x [31:0], unit_y [63:32], unit_z [95:64]

    coord_item_t pending_coords[$];
    unit_vec_t   expected_vectors[$];
    longint      atan_q32[0:llu_pkg::TAB_LEN-1];

    int unsigned accepted_total = 0;
    int unsigned checked_total = 0;
    int unsigned error_count = 0;
    int unsigned hold_cycles = 0;
    int unsigned ready_cycle = 0;
    int unsigned stall_left = 0;
    int unsigned coords_added = 0;

    latlon_to_unit_vector_unit #(
        .CORDIC_STAGES(STAGES)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Alternating arctangent series with 60 fraction bits: start at x, divide by d per term.
    function automatic longint unsigned arctan_series(longint unsigned x, longint unsigned d);
        longint unsigned sum;
        longint unsigned term;
        longint unsigned k;
        bit neg;
        sum = 0;
        k = 0;
        neg = 1'b0;
        while (x != 0)
        begin
            term = x / (2 * k + 1);
            sum = neg ? sum - term : sum + term;
            neg = !neg;
            x = x / d;
            k++;
        end
        return sum;
    endfunction

    // The first entry is pi/4 by Machin's formula, the rest atan(2^-i), all rounded to Q.32.
    function automatic void build_atan_table();
        longint unsigned one;
        longint unsigned v;
        one = 64'd1 << 60;
        v = 4 * arctan_series(one / 5, 25) - arctan_series(one / 239, 57121);
        atan_q32[0] = longint'((v + (64'd1 << 27)) >> 28);
        for (int i = 1; i < llu_pkg::TAB_LEN; i++)
        begin
            v = arctan_series(one >> i, 64'd1 << (2 * i));
            atan_q32[i] = longint'((v + (64'd1 << 27)) >> 28);
        end
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > ONE_L)
            return ONE_L;
        if (v < -ONE_L)
            return -ONE_L;
        return v;
    endfunction

    // Rotation-mode CORDIC from the gain-compensated start vector; angle in Q3.28.
    function automatic void rotate_angle(input longint ang, output longint cos_q30,
                                         output longint sin_q30);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = GAIN_L;
        y = 0;
        z = ang * 16;
        for (int i = 0; i < STAGES && i < llu_pkg::TAB_LEN; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_q32[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_q32[i];
            end
        end
        cos_q30 = clamp_unit((x + 2) >>> 2);
        sin_q30 = clamp_unit((y + 2) >>> 2);
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return clamp_unit((a * b + 64'sd536870912) >>> 30);
    endfunction

    function automatic unit_vec_t predict_unit_vector(logic [31:0] lat_bits,
                                                      logic [31:0] lon_bits);
        longint lat;
        longint lon;
        longint r;
        longint clat;
        longint slat;
        longint clon;
        longint slon;
        bit flip;
        unit_vec_t v;
        lat = longint'($signed(lat_bits));
        lon = longint'($signed(lon_bits));
        flip = 1'b0;

        // Clamp latitude at the poles.
        if (lat > HALF_PI_L)
            lat = HALF_PI_L;
        if (lat < -HALF_PI_L)
            lat = -HALF_PI_L;

        // Wrap longitude into [-pi, pi); the remainder truncates toward zero.
        r = (lon + PI_L) % TWO_PI_L;
        if (r < 0)
            r = r + TWO_PI_L;
        lon = r - PI_L;

        // Fold the outer half-plane by pi and negate the result afterward.
        if (lon > HALF_PI_L)
        begin
            lon = lon - PI_L;
            flip = 1'b1;
        end
        else if (lon < -HALF_PI_L)
        begin
            lon = lon + PI_L;
            flip = 1'b1;
        end

        rotate_angle(lat, clat, slat);
        rotate_angle(lon, clon, slon);
        if (flip)
        begin
            clon = -clon;
            slon = -slon;
        end

        v.unit_x = 32'(mul_q30(clat, clon));
        v.unit_y = 32'(mul_q30(clat, slon));
        v.unit_z = 32'(slat);
        return v;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones; every fourth run of 64 is gapless.
    function automatic int unsigned pick_gap(int unsigned idx);
        int unsigned r;
        if ((idx / 64) % 4 == 1)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_coord(int lat, int lon, bit drain);
        coord_item_t item;
        item.lat = lat;
        item.lon = lon;
        item.gap = pick_gap(coords_added);
        item.drain = drain;
        pending_coords.push_back(item);
        coords_added++;
    endtask

    // Angle near one of the boundaries that the clamp, wrap and fold depend on.
    function automatic int near_boundary();
        int base;
        case ($urandom_range(0, 6))
            0: base = HALF_PI_I;
            1: base = -HALF_PI_I;
            2: base = PI_I;
            3: base = -PI_I;
            4: base = 2 * PI_I;
            5: base = -2 * PI_I;
            default: base = 0;
        endcase
        return base + int'($urandom_range(0, 64)) - 32;
    endfunction

    // Stimulus, reset and end of run.
    initial
    begin
        int lat;
        int lon;
        build_atan_table();

        // Directed: poles, wrap points, fold points and the extremes of both fields.
        add_coord(0, 0, 1'b0);
        add_coord(HALF_PI_I, 0, 1'b0);
        add_coord(-HALF_PI_I, 0, 1'b0);
        add_coord(HALF_PI_I + 1, PI_I, 1'b0);
        add_coord(-HALF_PI_I - 1, -PI_I, 1'b0);
        add_coord(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        add_coord(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        add_coord(0, PI_I - 1, 1'b0);
        add_coord(0, HALF_PI_I, 1'b0);
        add_coord(0, HALF_PI_I + 1, 1'b0);
        add_coord(0, -HALF_PI_I, 1'b0);
        add_coord(0, -HALF_PI_I - 1, 1'b0);
        add_coord(0, 2 * PI_I, 1'b0);
        add_coord(0, -2 * PI_I, 1'b0);
        add_coord(100, PI_I + 1, 1'b0);
        add_coord(-100, -PI_I - 1, 1'b0);
        add_coord(1, -1, 1'b0);
        add_coord(-1, 1, 1'b0);
        add_coord(PI_I / 4, PI_I / 4, 1'b0);
        add_coord(32'h4000_0000, 32'hC000_0000, 1'b0);
        add_coord(32'h0FFF_FFFF, 32'hF000_0001, 1'b0);
        add_coord(HALF_PI_I - 1, -HALF_PI_I + 1, 1'b0);

        // Random: half in-range angles, the rest raw 32-bit values, boundaries and tiny angles.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
                begin
                    lat = int'($urandom_range(0, 2 * HALF_PI_I)) - HALF_PI_I;
                    lon = int'($urandom_range(0, 2 * PI_I - 1)) - PI_I;
                end
                10, 11, 12, 13, 14:
                begin
                    lat = $urandom();
                    lon = $urandom();
                end
                15, 16, 17:
                begin
                    lat = near_boundary();
                    lon = near_boundary();
                end
                default:
                begin
                    lat = int'($urandom()) >>> $urandom_range(0, 31);
                    lon = int'($urandom()) >>> $urandom_range(0, 31);
                end
            endcase
            // The sender waits for the pipeline to empty before the first and a middle item.
            add_coord(lat, lon, n == 0 || n == RANDOM_ITEMS / 2);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last item to be taken and its result to come back; the falling edge
        // sees the counters and handshake signals after they have settled.
        while (pending_coords.size() != 0 || s_tvalid)
            @(negedge clk);
        while (checked_total != accepted_total)
            @(negedge clk);
        repeat (LATENCY + 20) @(posedge clk);

        if (error_count == 0 && checked_total == accepted_total)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Driver: present the next coordinate after its gap; the prediction is made on acceptance.
    always @(posedge clk)
    begin
        logic        next_valid;
        logic [63:0] next_data;
        logic        taken;
        int unsigned acc_now;
        next_valid = s_tvalid;
        next_data = s_tdata;
        taken = s_tvalid && s_tready;
        acc_now = accepted_total + taken;
        if (taken)
        begin
            expected_vectors.push_back(predict_unit_vector(s_tdata[31:0], s_tdata[63:32]));
            next_valid = 1'b0;
        end
        if (rst_n && !next_valid && pending_coords.size() != 0)
        begin
            if (hold_cycles < pending_coords[0].gap)
                hold_cycles++;
            else if (!pending_coords[0].drain || acc_now == checked_total)
            begin
                next_data = {pending_coords[0].lon, pending_coords[0].lat};
                next_valid = 1'b1;
                void'(pending_coords.pop_front());
                hold_cycles = 0;
            end
        end
        s_tvalid <= next_valid;
        s_tdata <= next_data;
        accepted_total <= acc_now;
    end

    // Monitor: check each result against the oldest prediction and stall the output at random.
    always @(posedge clk)
    begin
        unit_vec_t   want;
        logic        next_ready;
        int unsigned r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (checked_total == accepted_total)
            begin
                $error("result with no item outstanding: %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = expected_vectors.pop_front();
                if ($signed(m_tdata[31:0]) !== want.unit_x)
                begin
                    $error("unit_x: expected %0d, got %0d", want.unit_x, $signed(m_tdata[31:0]));
                    error_count++;
                end
                if ($signed(m_tdata[63:32]) !== want.unit_y)
                begin
                    $error("unit_y: expected %0d, got %0d", want.unit_y, $signed(m_tdata[63:32]));
                    error_count++;
                end
                if ($signed(m_tdata[95:64]) !== want.unit_z)
                begin
                    $error("unit_z: expected %0d, got %0d", want.unit_z, $signed(m_tdata[95:64]));
                    error_count++;
                end
                checked_total <= checked_total + 1;
            end
        end

        // One window in eight runs without new stalls; a stall already running still ends first.
        ready_cycle++;
        if (stall_left > 0)
        begin
            stall_left--;
            next_ready = 1'b0;
        end
        else if (((ready_cycle / 128) % 8) == 3)
            next_ready = 1'b1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                next_ready = 1'b1;
            else
            begin
                next_ready = 1'b0;
                stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(10, 60);
            end
        end
        m_tready <= next_ready;
    end

    // Hard limit on the run time.
    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
